>>> hw/rtl/tfrt_pkg.sv
// ----------------------------------------------------------------------------
// tfrt_pkg
// Shared types and codes of the flow reassembly tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tfrt_pkg;

    localparam logic [1:0] REASON_FULL  = 2'd0;
    localparam logic [1:0] REASON_EVICT = 2'd1;
    localparam logic [1:0] REASON_FIN   = 2'd2;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
    } tuple_t;

    typedef struct packed {
        tuple_t      tup;
        logic [11:0] payload_len;
        logic        fin_flag;
        logic        len_fits;
    } hdr_t;

    typedef struct packed {
        tuple_t      tup;
        logic [11:0] bytes;
        logic [1:0]  reason;
        logic [31:0] number;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/tcp_flow_reassembly_tracker_core.sv
// ----------------------------------------------------------------------------
// tcp_flow_reassembly_tracker_core
// TCP flow table with fill tracking and oldest-first eviction.
// ----------------------------------------------------------------------------
// Each input transaction is one TCP header (4-tuple, payload length, FIN).
// The block looks the flow up among FLOWS entries by exact 4-tuple and adds
// the payload to the flow's fill count. A flow whose fill would reach BUF is
// flushed first and the payload retried (dropped if it still does not fit).
// An unknown flow is inserted at the young end; with the table full, the
// oldest flow is flushed and evicted first. FIN flushes the flow, even when
// empty, and removes it. Each flush is one output transaction carrying the
// flow tuple, byte count (low 12 bits), reason (tuser) and a running flush
// number; tlast marks the last flush caused by a header. A header passes
// through queue pop, parallel tuple compare, fill RAM read and update, then
// its flushes are delivered in turn; the registered fill RAM read and the
// compare of all flow cells set these steps. A two-entry header queue lets
// intake continue while the engine works or the output is stalled. After
// reset the table is empty and ready at once: no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_flow_reassembly_tracker_core
    import tfrt_pkg::*;
#(
    parameter int FLOWS = 64,
    parameter int BUF   = 4096
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // src_addr[31:0], dst_addr[63:32], src_port_num[79:64],
    // dst_port_num[95:80], payload_len[107:96], zero pad[111:108]
    input  wire logic [111:0] s_tdata,
    // fin_flag[0]
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_src_addr[31:0], out_dst_addr[63:32], out_src_port[79:64],
    // out_dst_port[95:80], flushed_bytes[107:96], flush_number[139:108],
    // zero pad[143:140]
    output logic [143:0]      m_tdata,
    // flush_reason[1:0]
    output logic [1:0]        m_tuser,
    // last_of_run
    output logic              m_tlast
);

    tuple_t  in_tup;
    logic    q_valid, q_pop;
    hdr_t    q_hdr;
    result_t res;

    assign in_tup.src_addr = s_tdata[31:0];
    assign in_tup.dst_addr = s_tdata[63:32];
    assign in_tup.sport    = s_tdata[79:64];
    assign in_tup.dport    = s_tdata[95:80];

    tfrt_front #(.BUF(BUF)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_tup   (in_tup),
        .in_len   (s_tdata[107:96]),
        .in_fin   (s_tuser[0]),
        .q_valid  (q_valid),
        .q_hdr    (q_hdr),
        .q_pop    (q_pop)
    );

    tfrt_back #(.FLOWS(FLOWS), .BUF(BUF)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_hdr     (q_hdr),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'd0, res.number, res.bytes, res.tup.dport, res.tup.sport,
                      res.tup.dst_addr, res.tup.src_addr};
    assign m_tuser = res.reason;

endmodule

`default_nettype wire

>>> hw/rtl/tfrt_ram.sv
// ----------------------------------------------------------------------------
// tfrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tfrt_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/tfrt_front.sv
// ----------------------------------------------------------------------------
// tfrt_front
// Header intake: accepts transactions, tags oversized payloads, and queues
// them in a two-entry FIFO for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tfrt_front
    import tfrt_pkg::*;
#(
    parameter int BUF = 4096
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire tuple_t       in_tup,
    input  wire logic [11:0]  in_len,
    input  wire logic         in_fin,
    output logic              q_valid,
    output hdr_t              q_hdr,
    input  wire logic         q_pop
);

    localparam int LW = ($clog2(BUF) > 12 ? $clog2(BUF) : 12) + 1;

    hdr_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    hdr_t       new_hdr;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_hdr    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        new_hdr.tup         = in_tup;
        new_hdr.payload_len = in_len;
        new_hdr.fin_flag    = in_fin;
        new_hdr.len_fits    = (LW'(in_len) < LW'(BUF));
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_hdr;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tfrt_cells.sv
// ----------------------------------------------------------------------------
// tfrt_cells
// Row of flow cells: valid bit, 4-tuple and age rank per slot, with the
// parallel tuple compare and the hit, free and oldest slot encoders.
// ----------------------------------------------------------------------------
`default_nettype none

module tfrt_cells
    import tfrt_pkg::*;
#(
    parameter int FLOWS = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire tuple_t                   key,
    output logic                          hit,
    output logic [$clog2(FLOWS)-1:0]      hit_slot,
    output logic [$clog2(FLOWS)-1:0]      hit_rank,
    output logic                          free_found,
    output logic [$clog2(FLOWS)-1:0]      free_slot,
    output logic                          old_found,
    output logic [$clog2(FLOWS)-1:0]      old_slot,
    input  wire logic                     rm_en,
    input  wire logic [$clog2(FLOWS)-1:0] rm_slot,
    input  wire logic [$clog2(FLOWS)-1:0] rm_rank,
    input  wire logic                     ins_en,
    input  wire logic [$clog2(FLOWS)-1:0] ins_slot,
    input  wire logic [$clog2(FLOWS)-1:0] ins_rank
);

    localparam int SW = $clog2(FLOWS);

    logic          valid_reg [FLOWS];
    tuple_t        tup_reg   [FLOWS];
    logic [SW-1:0] rank_reg  [FLOWS];

    // Descending scan so the lowest slot wins.
    always_comb
    begin
        hit        = 1'b0;
        hit_slot   = '0;
        hit_rank   = '0;
        free_found = 1'b0;
        free_slot  = '0;
        old_found  = 1'b0;
        old_slot   = '0;
        for (int i = FLOWS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (tup_reg[i] == key))
            begin
                hit      = 1'b1;
                hit_slot = SW'(i);
                hit_rank = rank_reg[i];
            end
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
            if (valid_reg[i] && (rank_reg[i] == '0))
            begin
                old_found = 1'b1;
                old_slot  = SW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FLOWS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < FLOWS; i++)
            begin
                if (ins_en && (ins_slot == SW'(i)))
                begin
                    valid_reg[i] <= 1'b1;
                end
                else if (rm_en && (rm_slot == SW'(i)))
                begin
                    valid_reg[i] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FLOWS; i++)
        begin
            if (ins_en && (ins_slot == SW'(i)))
            begin
                tup_reg[i]  <= key;
                rank_reg[i] <= ins_rank;
            end
            else if (rm_en && valid_reg[i] && (rank_reg[i] > rm_rank))
            begin
                rank_reg[i] <= rank_reg[i] - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tfrt_back.sv
// ----------------------------------------------------------------------------
// tfrt_back
// Flow update engine: looks up the queued header, updates fill and age
// order, builds up to two flush records and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tfrt_back
    import tfrt_pkg::*;
#(
    parameter int FLOWS = 64,
    parameter int BUF   = 4096
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    input  wire hdr_t  q_hdr,
    output logic       q_pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_res,
    output logic       out_last
);

    localparam int SW   = $clog2(FLOWS);
    localparam int CW   = $clog2(FLOWS + 1);
    localparam int FW   = $clog2(BUF);
    localparam int SUMW = (FW > 12 ? FW : 12) + 1;
    localparam int RAMW = $bits(tuple_t) + FW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOOK = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_EXEC = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]    state_reg, state_next;
    hdr_t          hdr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   flush_cnt_reg, flush_cnt_next;
    logic          hit_reg, free_found_reg, old_found_reg, full_reg;
    logic [SW-1:0] hit_slot_reg, hit_rank_reg, free_slot_reg, old_slot_reg;
    result_t       res_reg [2];
    logic [1:0]    nres_reg;
    logic          idx_reg;
    logic          out_valid_reg;
    result_t       out_res_reg;
    logic          out_last_reg;

    logic          hit, free_found, old_found;
    logic [SW-1:0] hit_slot, hit_rank, free_slot, old_slot;
    logic          rm_en, ins_en;
    logic [SW-1:0] rm_slot, rm_rank, ins_slot, ins_rank;
    logic          ram_we;
    logic [SW-1:0] ram_waddr, ram_raddr;
    logic [RAMW-1:0] ram_wdata, ram_rdata;
    tuple_t        rd_tup;
    logic [FW-1:0] rd_fill, new_fill;
    logic [SUMW-1:0] sum;
    result_t       r0, r1;
    logic [1:0]    n;
    logic          can_load;

    tfrt_cells #(.FLOWS(FLOWS)) u_cells (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (hdr_reg.tup),
        .hit        (hit),
        .hit_slot   (hit_slot),
        .hit_rank   (hit_rank),
        .free_found (free_found),
        .free_slot  (free_slot),
        .old_found  (old_found),
        .old_slot   (old_slot),
        .rm_en      (rm_en),
        .rm_slot    (rm_slot),
        .rm_rank    (rm_rank),
        .ins_en     (ins_en),
        .ins_slot   (ins_slot),
        .ins_rank   (ins_rank)
    );

    tfrt_ram #(.W(RAMW), .D(FLOWS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign ram_raddr = hit_reg ? hit_slot_reg : old_slot_reg;
    assign rd_tup    = ram_rdata[RAMW-1:FW];
    assign rd_fill   = ram_rdata[FW-1:0];
    assign can_load  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        sum      = SUMW'(rd_fill) + SUMW'(hdr_reg.payload_len);
        r0       = '0;
        r1       = '0;
        n        = 2'd0;
        rm_en    = 1'b0;
        rm_slot  = '0;
        rm_rank  = '0;
        ins_en   = 1'b0;
        ins_slot = full_reg ? old_slot_reg : free_slot_reg;
        ins_rank = SW'(full_reg ? (cnt_reg - 1'b1) : cnt_reg);
        cnt_next = cnt_reg;
        if (hdr_reg.len_fits == 1'b0)
        begin
            new_fill = '0;
        end
        else
        begin
            new_fill = FW'(SUMW'(hdr_reg.payload_len));
        end
        if (hit_reg)
        begin
            if (sum < SUMW'(BUF))
            begin
                new_fill = sum[FW-1:0];
            end
            else
            begin
                r0.tup    = hdr_reg.tup;
                r0.bytes  = 12'(SUMW'(rd_fill));
                r0.reason = REASON_FULL;
                n         = 2'd1;
            end
        end
        else if (full_reg)
        begin
            r0.tup    = rd_tup;
            r0.bytes  = 12'(SUMW'(rd_fill));
            r0.reason = REASON_EVICT;
            n         = 2'd1;
            rm_en     = 1'b1;
            rm_slot   = old_slot_reg;
            rm_rank   = '0;
            cnt_next  = cnt_reg - 1'b1;
        end
        if (!hit_reg && !hdr_reg.fin_flag)
        begin
            ins_en   = 1'b1;
            cnt_next = cnt_next + 1'b1;
        end
        if (hdr_reg.fin_flag)
        begin
            if (n == 2'd0)
            begin
                r0.tup    = hdr_reg.tup;
                r0.bytes  = 12'(SUMW'(new_fill));
                r0.reason = REASON_FIN;
            end
            else
            begin
                r1.tup    = hdr_reg.tup;
                r1.bytes  = 12'(SUMW'(new_fill));
                r1.reason = REASON_FIN;
            end
            if (hit_reg)
            begin
                rm_en    = 1'b1;
                rm_slot  = hit_slot_reg;
                rm_rank  = hit_rank_reg;
                cnt_next = cnt_reg - 1'b1;
            end
            n = n + 2'd1;
        end
        r0.number = flush_cnt_reg + 32'd1;
        r1.number = flush_cnt_reg + 32'd2;
        ram_waddr = hit_reg ? hit_slot_reg : ins_slot;
        ram_wdata = {hdr_reg.tup, new_fill};
        ram_we    = (state_reg == ST_EXEC) && !hdr_reg.fin_flag;
        if (state_reg != ST_EXEC)
        begin
            rm_en  = 1'b0;
            ins_en = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        flush_cnt_next = flush_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                flush_cnt_next = flush_cnt_reg + 32'(n);
                state_next     = (n == 2'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (can_load && (2'(idx_reg) + 2'd1 == nres_reg))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            flush_cnt_reg <= '0;
            nres_reg      <= 2'd0;
            idx_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flush_cnt_reg <= flush_cnt_next;
            if (state_reg == ST_EXEC)
            begin
                cnt_reg  <= cnt_next;
                nres_reg <= n;
                idx_reg  <= 1'b0;
            end
            if (state_reg == ST_EMIT && can_load)
            begin
                idx_reg <= 1'b1;
            end
            if (can_load)
            begin
                out_valid_reg <= (state_reg == ST_EMIT);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            hdr_reg <= q_hdr;
        end
        if (state_reg == ST_LOOK)
        begin
            hit_reg        <= hit;
            hit_slot_reg   <= hit_slot;
            hit_rank_reg   <= hit_rank;
            free_found_reg <= free_found;
            free_slot_reg  <= free_slot;
            old_found_reg  <= old_found;
            old_slot_reg   <= old_slot;
            full_reg       <= (cnt_reg == CW'(FLOWS));
        end
        if (state_reg == ST_EXEC)
        begin
            res_reg[0] <= r0;
            res_reg[1] <= r1;
        end
        if (state_reg == ST_EMIT && can_load)
        begin
            out_res_reg  <= res_reg[idx_reg];
            out_last_reg <= (2'(idx_reg) + 2'd1 == nres_reg);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(FLOWS))
        else $error("flow count above table size");

    a_evict_has_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) && !hit_reg && full_reg |-> old_found_reg)
        else $error("full table without an oldest flow");

    a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) && !hit_reg && !full_reg |-> free_found_reg)
        else $error("table not full but no free slot");

    a_second_is_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && (nres_reg == 2'd2) |-> res_reg[1].reason == REASON_FIN)
        else $error("second flush of a packet is not a FIN flush");

endmodule

`default_nettype wire

>>> test/tb_tcp_flow_reassembly_tracker_core.sv
// ----------------------------------------------------------------------------
// tb_tcp_flow_reassembly_tracker_core
// Self-checking bench for the TCP flow table with oldest-first eviction.
// ----------------------------------------------------------------------------
// Headers go in over the slave stream. A behavioral flow table in the bench
// predicts every flush transaction, and each output transaction is compared
// field by field with the oldest prediction. A short table of directed rows
// runs first: extremes, FIN on an empty flow, oversized payloads and double
// flushes. A run of sequential tuples then fills the table and overflows it
// into evictions. Random traffic follows. It draws mostly from a small pool
// of tuples, so flows fill up and get flushed, and the rest are fresh tuples
// that force evictions. The sender runs in bursts with random gaps. The
// receiver stalls on a rotating pattern of its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tcp_flow_reassembly_tracker_core;
    import tfrt_pkg::*;

    localparam int FLOWS     = 64;
    localparam int BUF       = 4096;
    localparam int N_RANDOM  = 1100;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        tuple_t      tup;
        logic [11:0] len;
        logic        fin;
    } pkt_t;

    // Directed row: header plus an optional typed-in expectation.
    typedef struct {
        pkt_t        pkt;
        bit          has_exp;
        int          exp_n;
        logic [11:0] exp_bytes0;
        logic [1:0]  exp_reason0;
    } row_t;

    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [111:0]   s_tdata;
    logic [0:0]     s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [143:0]   m_tdata;
    logic [1:0]     m_tuser;
    logic           m_tlast;

    tcp_flow_reassembly_tracker_core #(
        .FLOWS (FLOWS),
        .BUF   (BUF)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Flow table mirror; age 0 is the oldest flow.
    bit          flow_valid [FLOWS];
    tuple_t      flow_tup   [FLOWS];
    int unsigned flow_fill  [FLOWS];
    int unsigned flow_age   [FLOWS];
    int unsigned live_flows;
    logic [31:0] flush_total;

    typedef struct packed {
        result_t res;
        logic    last;
    } flush_t;

    flush_t      pending_flushes[$];
    int          errors;
    int          cycle;
    tuple_t      pool [16];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) cycle <= cycle + 1;

    function automatic void table_reset();
        for (int i = 0; i < FLOWS; i++) begin
            flow_valid[i] = 1'b0;
        end
        live_flows  = 0;
        flush_total = '0;
    endfunction

    function automatic void push_flush(int slot, logic [1:0] reason);
        flush_t f;
        flush_total    = flush_total + 32'd1;
        f.res.tup      = flow_tup[slot];
        f.res.bytes    = flow_fill[slot][11:0];
        f.res.reason   = reason;
        f.res.number   = flush_total;
        f.last         = 1'b0;
        pending_flushes = {pending_flushes, f};
        flow_fill[slot] = 0;
    endfunction

    function automatic void drop_flow(int slot);
        int unsigned r;
        r = flow_age[slot];
        flow_valid[slot] = 1'b0;
        for (int i = 0; i < FLOWS; i++) begin
            if (flow_valid[i] && flow_age[i] > r) begin
                flow_age[i]--;
            end
        end
        if (live_flows > 0) begin
            live_flows--;
        end
    endfunction

    // Predicts the flushes one header causes; returns how many.
    function automatic int predict_flushes(pkt_t p);
        int slot;
        int n;
        slot = -1;
        n    = 0;
        for (int i = 0; i < FLOWS; i++) begin
            if (slot < 0 && flow_valid[i] && flow_tup[i] == p.tup) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            if (flow_fill[slot] + p.len < BUF) begin
                flow_fill[slot] += p.len;
            end else begin
                push_flush(slot, REASON_FULL);
                n++;
                if (flow_fill[slot] + p.len < BUF) begin
                    flow_fill[slot] += p.len;
                end
            end
        end else begin
            if (live_flows >= FLOWS) begin
                for (int i = 0; i < FLOWS; i++) begin
                    if (n == 0 && flow_valid[i] && flow_age[i] == 0) begin
                        push_flush(i, REASON_EVICT);
                        n++;
                        drop_flow(i);
                    end
                end
            end
            for (int i = FLOWS - 1; i >= 0; i--) begin
                if (!flow_valid[i]) begin
                    slot = i;
                end
            end
            flow_valid[slot] = 1'b1;
            flow_tup[slot]   = p.tup;
            flow_fill[slot]  = 0;
            flow_age[slot]   = live_flows;
            live_flows++;
            if (p.len < BUF) begin
                flow_fill[slot] = p.len;
            end
        end
        if (p.fin) begin
            push_flush(slot, REASON_FIN);
            n++;
            drop_flow(slot);
        end
        if (n > 0) begin
            pending_flushes[pending_flushes.size() - 1].last = 1'b1;
        end
        return n;
    endfunction

    // Output side: rotating stall pattern, compare on each transaction.
    logic [15:0] stall_pattern;
    initial stall_pattern = 16'b1011_0011_1111_0100;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
            // While bit 12 of the cycle counter is set, run with no stalls.
            m_tready <= cycle[12] ? 1'b1 : stall_pattern[15];
        end
    end

    always @(posedge clk) begin
        flush_t e;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_flushes.size() == 0) begin
                $error("unexpected flush transaction, tdata %h", m_tdata);
                errors++;
            end else begin
                e = pending_flushes.pop_front();
                if (m_tdata[31:0] !== e.res.tup.src_addr) begin
                    $error("out_src_addr exp %h got %h", e.res.tup.src_addr,
                           m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== e.res.tup.dst_addr) begin
                    $error("out_dst_addr exp %h got %h", e.res.tup.dst_addr,
                           m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[79:64] !== e.res.tup.sport) begin
                    $error("out_src_port exp %h got %h", e.res.tup.sport,
                           m_tdata[79:64]);
                    errors++;
                end
                if (m_tdata[95:80] !== e.res.tup.dport) begin
                    $error("out_dst_port exp %h got %h", e.res.tup.dport,
                           m_tdata[95:80]);
                    errors++;
                end
                if (m_tdata[107:96] !== e.res.bytes) begin
                    $error("flushed_bytes exp %0d got %0d", e.res.bytes,
                           m_tdata[107:96]);
                    errors++;
                end
                if (m_tdata[139:108] !== e.res.number) begin
                    $error("flush_number exp %0d got %0d", e.res.number,
                           m_tdata[139:108]);
                    errors++;
                end
                if (m_tuser !== e.res.reason) begin
                    $error("flush_reason exp %0d got %0d", e.res.reason, m_tuser);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_of_run exp %0d got %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Drives one header and holds it until accepted. The predictor runs
    // at acceptance, so expectations are in place before any flush comes.
    task automatic send_header(pkt_t p, output int n_flushes);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, p.len, p.tup.dport, p.tup.sport,
                     p.tup.dst_addr, p.tup.src_addr};
        s_tuser  <= p.fin;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        n_flushes = predict_flushes(p);
    endtask

    task automatic idle_cycles(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic tuple_t rand_tuple();
        tuple_t t;
        t.src_addr = $urandom;
        t.dst_addr = $urandom;
        t.sport    = 16'($urandom);
        t.dport    = 16'($urandom);
        return t;
    endfunction

    function automatic tuple_t seq_tuple(int k);
        tuple_t t;
        t.src_addr = 32'h0a00_0000 + 32'(k);
        t.dst_addr = 32'hc0a8_0001;
        t.sport    = 16'd1000 + 16'(k);
        t.dport    = 16'd80;
        return t;
    endfunction

    function automatic row_t mk_row(tuple_t t, logic [11:0] len, logic fin,
                                    bit has_exp, int n, logic [11:0] b,
                                    logic [1:0] r);
        row_t w;
        w.pkt.tup      = t;
        w.pkt.len      = len;
        w.pkt.fin      = fin;
        w.has_exp      = has_exp;
        w.exp_n        = n;
        w.exp_bytes0   = b;
        w.exp_reason0  = r;
        return w;
    endfunction

    row_t directed[$];

    initial begin
        tuple_t t_max;
        tuple_t t_zero;
        pkt_t   p;
        int     n;
        int     burst;
        flush_t head;

        errors   = 0;
        cycle    = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        table_reset();

        t_max  = '1;
        t_zero = '0;
        // All-ones tuple: 4095 fits, 1 more forces a buffer-full flush.
        directed = {directed,
                    mk_row(t_max, 12'd4095, 1'b0, 1'b1, 0, 12'd0, 2'd0)};
        directed = {directed,
                    mk_row(t_max, 12'd1, 1'b0, 1'b1, 1, 12'd4095, REASON_FULL)};
        // Flush plus FIN on the same packet: two flushes.
        directed = {directed,
                    mk_row(t_max, 12'd4095, 1'b1, 1'b1, 2, 12'd1, REASON_FULL)};
        // FIN on a brand-new empty flow: empty flush.
        directed = {directed,
                    mk_row(t_zero, 12'd0, 1'b1, 1'b1, 1, 12'd0, REASON_FIN)};
        // New flow with maximum payload, then a known-flow oversized retry.
        directed = {directed,
                    mk_row(t_zero, 12'd4095, 1'b0, 1'b1, 0, 12'd0, 2'd0)};
        directed = {directed,
                    mk_row(t_zero, 12'd4095, 1'b0, 1'b1, 1, 12'd4095, REASON_FULL)};
        directed = {directed,
                    mk_row(t_zero, 12'd0, 1'b1, 1'b1, 1, 12'd4095, REASON_FIN)};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k]) begin
            int first_idx;
            send_header(directed[k].pkt, n);
            first_idx = pending_flushes.size() - n;
            if (directed[k].has_exp) begin
                if (n != directed[k].exp_n) begin
                    $error("flush count exp %0d got %0d", directed[k].exp_n, n);
                    errors++;
                end else if (n > 0) begin
                    head = pending_flushes[first_idx];
                    if (head.res.bytes !== directed[k].exp_bytes0 ||
                        head.res.reason !== directed[k].exp_reason0) begin
                        $error("flushed_bytes/reason exp %0d/%0d got %0d/%0d",
                               directed[k].exp_bytes0, directed[k].exp_reason0,
                               head.res.bytes, head.res.reason);
                        errors++;
                    end
                end
            end
        end

        // Fill the table to FLOWS, then overflow it: evictions, one with FIN.
        for (int k = 0; k < FLOWS + 4; k++) begin
            p.tup = seq_tuple(k);
            p.len = 12'(k);
            p.fin = (k == FLOWS + 2);
            send_header(p, n);
        end

        // Pause until every predicted flush has come out.
        s_tvalid <= 1'b0;
        while (pending_flushes.size() != 0 && cycle < MAX_CYCLE) begin
            @(posedge clk);
        end

        for (int k = 0; k < 16; k++) begin
            pool[k] = rand_tuple();
        end

        burst = 0;
        for (int k = 0; k < N_RANDOM; k++) begin
            int sel;
            sel   = $urandom_range(0, 99);
            p.tup = (sel < 75) ? pool[$urandom_range(0, 15)] : rand_tuple();
            case ($urandom_range(0, 3))
                0: p.len = 12'($urandom);
                1: p.len = 12'($urandom_range(3000, 4095));
                default: p.len = 12'($urandom_range(0, 1500));
            endcase
            p.fin = ($urandom_range(0, 9) == 0);
            send_header(p, n);
            if (burst == 0) begin
                idle_cycles($urandom_range(1, 12));
                burst = $urandom_range(1, 20);
            end else begin
                burst--;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_flushes.size() != 0 && cycle < MAX_CYCLE) begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);

        if (cycle >= MAX_CYCLE) begin
            $display("FAIL");
        end else if (errors == 0 && pending_flushes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    always @(posedge clk) begin
        if (cycle == MAX_CYCLE + 1000) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule

`default_nettype wire
